// ===== hdl/cbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types, field widths, register indexes and the control store of the
// contiguous balanced partitioner.
// ----------------------------------------------------------------------------
package cbp_pkg;

    localparam int CFG_W        = 32;
    localparam int BIN_COUNT_W  = 5;
    localparam int TOTAL_W      = 32;
    localparam int ITEM_COUNT_W = 16;
    localparam int ITEM_W_W     = 24;
    localparam int BIN_IDX_W    = 4;
    localparam int CFG_IDX_W    = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BIN_COUNT  = 2'd0;
    localparam t_cfg_idx CFG_TOTAL      = 2'd1;
    localparam t_cfg_idx CFG_ITEM_COUNT = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_START,
        OP_OPEN,
        OP_SHARE,
        OP_CLOSE,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN,
        WT_DIV,
        WT_OUT
    } t_wait;

    typedef enum logic [1:0] {
        CD_ALWAYS,
        CD_FIRST,
        CD_LAST,
        CD_CLOSE
    } t_cond;

    typedef logic [2:0] t_upc;

    localparam t_upc S_IDLE  = 3'd0;
    localparam t_upc S_START = 3'd1;
    localparam t_upc S_CHECK = 3'd2;
    localparam t_upc S_OPEN  = 3'd3;
    localparam t_upc S_WAIT  = 3'd4;
    localparam t_upc S_CLOSE = 3'd5;
    localparam t_upc S_EMIT  = 3'd6;

    typedef struct packed {
        t_wait wt;
        t_op   op;
        t_cond cd;
        t_upc  tgt_t;
        t_upc  tgt_f;
    } t_uword;

    typedef struct packed {
        logic last_bin;
        logic close;
    } t_dp_stat;

    typedef struct packed {
        logic     in_valid;
        logic     first;
        logic     out_free;
        logic     div_done;
        t_dp_stat dp;
    } t_stat;

    function automatic t_uword cbp_urom(input t_upc pc);
        t_uword w;
        case (pc)
            S_IDLE:  w = '{WT_IN,   OP_TAKE,  CD_FIRST,  S_START, S_CHECK};
            S_START: w = '{WT_NONE, OP_START, CD_ALWAYS, S_OPEN,  S_OPEN};
            S_CHECK: w = '{WT_NONE, OP_NONE,  CD_CLOSE,  S_CLOSE, S_EMIT};
            S_OPEN:  w = '{WT_NONE, OP_OPEN,  CD_LAST,   S_CHECK, S_WAIT};
            S_WAIT:  w = '{WT_DIV,  OP_SHARE, CD_ALWAYS, S_CHECK, S_CHECK};
            S_CLOSE: w = '{WT_NONE, OP_CLOSE, CD_ALWAYS, S_OPEN,  S_OPEN};
            S_EMIT:  w = '{WT_OUT,  OP_EMIT,  CD_ALWAYS, S_IDLE,  S_IDLE};
            default: w = '{WT_NONE, OP_NONE,  CD_ALWAYS, S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/cbp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_seq
// Step counter over the control store: waits, issues one datapath operation
// per step and takes conditional jumps on input and datapath status.
// ----------------------------------------------------------------------------
module cbp_seq
    import cbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_in_ready
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword n_uw;
    logic   n_go;
    logic   n_cond;

    always_comb begin
        n_uw = cbp_urom(r_pc);
        case (n_uw.wt)
            WT_NONE: n_go = 1'b1;
            WT_IN:   n_go = i_stat.in_valid;
            WT_DIV:  n_go = i_stat.div_done;
            WT_OUT:  n_go = i_stat.out_free;
            default: n_go = 1'b0;
        endcase
        case (n_uw.cd)
            CD_ALWAYS: n_cond = 1'b1;
            CD_FIRST:  n_cond = i_stat.first;
            CD_LAST:   n_cond = i_stat.dp.last_bin;
            CD_CLOSE:  n_cond = i_stat.dp.close;
            default:   n_cond = 1'b1;
        endcase
        o_op = n_go ? n_uw.op : OP_NONE;
        n_pc = n_go ? (n_cond ? n_uw.tgt_t : n_uw.tgt_f) : r_pc;
    end

    assign o_in_ready = (r_pc == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/cbp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_div
// Radix-2 restoring divider: one quotient bit per cycle, weight by bin count.
// ----------------------------------------------------------------------------
module cbp_div
    import cbp_pkg::*;
#(
    parameter int WEIGHT_BITS = 32,
    parameter int DIVISOR_W   = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [WEIGHT_BITS-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]   i_divisor,
    output logic [WEIGHT_BITS-1:0] o_quotient,
    output logic                   o_done
);

    localparam int CW = $clog2(WEIGHT_BITS + 1);

    logic [CW-1:0]          r_cnt;
    logic [WEIGHT_BITS-1:0] r_quo;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   r_dvs;
    logic [DIVISOR_W:0]     n_rem_sh;
    logic [DIVISOR_W:0]     n_diff;
    logic                   n_qbit;

    assign n_rem_sh = {r_rem, r_quo[WEIGHT_BITS-1]};
    assign n_qbit   = (n_rem_sh >= {1'b0, r_dvs});
    assign n_diff   = n_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(WEIGHT_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_qbit ? n_diff[DIVISOR_W-1:0] : n_rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[WEIGHT_BITS-2:0], n_qbit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = (r_cnt == '0);

endmodule

// ===== hdl/cbp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_dp
// Partition datapath: configuration registers, open-bin state, close test and
// the operations issued by the sequencer.
// ----------------------------------------------------------------------------
module cbp_dp
    import cbp_pkg::*;
#(
    parameter int MAX_BINS    = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_op                          i_op,
    input  logic                         i_cfg_we,
    input  t_cfg_idx                     i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic [ITEM_W_W-1:0]          i_item_weight,
    input  logic [WEIGHT_BITS-1:0]       i_quotient,
    output logic [WEIGHT_BITS-1:0]       o_dividend,
    output logic [$clog2(MAX_BINS+1)-1:0] o_divisor,
    output logic [BIN_IDX_W-1:0]         o_bin_index,
    output t_dp_stat                     o_stat
);

    localparam int CB = $clog2(MAX_BINS);
    localparam int BR = $clog2(MAX_BINS + 1);
    localparam int NW = (BR > BIN_COUNT_W) ? BR : BIN_COUNT_W;
    localparam int LW = (BR > ITEM_COUNT_W) ? BR : ITEM_COUNT_W;
    localparam int SW = ((WEIGHT_BITS > ITEM_W_W) ? WEIGHT_BITS : ITEM_W_W) + 1;

    logic [BIN_COUNT_W-1:0]  r_bin_count;
    logic [TOTAL_W-1:0]      r_total;
    logic [ITEM_COUNT_W-1:0] r_item_count;

    logic [ITEM_W_W-1:0]     r_w;
    logic [CB-1:0]           r_cur_bin;
    logic [WEIGHT_BITS-1:0]  r_fill;
    logic [WEIGHT_BITS-1:0]  r_wleft;
    logic [BR-1:0]           r_brem;
    logic [ITEM_COUNT_W-1:0] r_taken;
    logic [WEIGHT_BITS-1:0]  r_share;

    logic [NW-1:0]           n_bc;
    logic [BR-1:0]           n_bins;
    logic [ITEM_COUNT_W-1:0] n_left;
    logic                    n_few;
    logic                    n_not_last;
    logic                    n_full;
    logic                    n_over;
    logic [WEIGHT_BITS-1:0]  n_gap;
    logic [SW-1:0]           n_sum;
    logic [WEIGHT_BITS-1:0]  n_fill;
    logic [WEIGHT_BITS-1:0]  n_wleft;

    always_comb begin
        n_bc = NW'(r_bin_count);
        if (n_bc == '0) begin
            n_bins = BR'(1);
        end else if (n_bc > NW'(MAX_BINS)) begin
            n_bins = BR'(MAX_BINS);
        end else begin
            n_bins = BR'(n_bc);
        end
    end

    assign n_not_last = (r_brem > BR'(1));
    assign n_left     = (r_taken < r_item_count) ? (r_item_count - r_taken) : '0;
    assign n_few      = (LW'(n_left) <= LW'(r_brem - BR'(1)));
    assign n_full     = (r_fill >= r_share);
    assign n_gap      = r_share - r_fill;
    assign n_over     = (SW'(r_w) > SW'({n_gap, 1'b0}));

    assign n_sum   = SW'(r_fill) + SW'(r_w);
    assign n_fill  = (n_sum > SW'({WEIGHT_BITS{1'b1}})) ? {WEIGHT_BITS{1'b1}}
                                                        : n_sum[WEIGHT_BITS-1:0];
    assign n_wleft = (r_wleft > r_fill) ? (r_wleft - r_fill) : '0;

    assign o_stat.last_bin = !n_not_last;
    assign o_stat.close    = n_not_last && (n_few || ((r_fill != '0) && (n_full || n_over)));

    assign o_dividend  = r_wleft;
    assign o_divisor   = r_brem;
    assign o_bin_index = BIN_IDX_W'(r_cur_bin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count  <= BIN_COUNT_W'(2);
            r_total      <= '0;
            r_item_count <= ITEM_COUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIN_COUNT:  r_bin_count  <= i_cfg_data[BIN_COUNT_W-1:0];
                CFG_TOTAL:      r_total      <= i_cfg_data[TOTAL_W-1:0];
                CFG_ITEM_COUNT: r_item_count <= i_cfg_data[ITEM_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_TAKE) begin
            r_w <= i_item_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_bin <= '0;
            r_fill    <= '0;
            r_wleft   <= '0;
            r_brem    <= '0;
            r_taken   <= '0;
            r_share   <= '0;
        end else begin
            case (i_op)
                OP_START: begin
                    r_brem    <= n_bins;
                    r_cur_bin <= '0;
                    r_wleft   <= WEIGHT_BITS'(r_total);
                    r_taken   <= '0;
                end
                OP_OPEN: begin
                    r_fill  <= '0;
                    r_share <= r_wleft;
                end
                OP_SHARE: begin
                    r_share <= i_quotient;
                end
                OP_CLOSE: begin
                    r_wleft   <= n_wleft;
                    r_brem    <= r_brem - BR'(1);
                    r_cur_bin <= r_cur_bin + CB'(1);
                end
                OP_EMIT: begin
                    r_fill <= n_fill;
                    if (r_taken != {ITEM_COUNT_W{1'b1}}) begin
                        r_taken <= r_taken + ITEM_COUNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/contiguous_balanced_partitioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_balanced_partitioner_core
// Cuts a sorted stream of item weights into contiguous runs, one per bin, and
// answers each item with its bin index.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   input    | i_in_valid / o_in_ready     | i_item_weight, i_first_item
//   output   | o_out_valid / i_out_ready   | o_bin_index
//   config   | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// An item that closes no bin passes the take, check and emit steps. Opening
// a set adds the start and open steps and a share division, skipped when the
// set has a single bin; each closed bin adds the close and open steps and a
// division, skipped when the next bin is the last. The share divider yields
// one quotient bit per cycle. Reset is synchronous, active low, and needs no
// clearing pass. A full output register holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module contiguous_balanced_partitioner_core
    import cbp_pkg::*;
#(
    parameter int MAX_BINS    = 16,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ITEM_W_W-1:0]  i_item_weight,
    input  logic                 i_first_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BIN_IDX_W-1:0] o_bin_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int BR = $clog2(MAX_BINS + 1);

    t_op                    n_op;
    t_stat                  n_stat;
    t_dp_stat               n_dp_stat;
    logic [WEIGHT_BITS-1:0] n_dividend;
    logic [WEIGHT_BITS-1:0] n_quotient;
    logic [BR-1:0]          n_divisor;
    logic                   n_div_done;
    logic [BIN_IDX_W-1:0]   n_bin;
    logic                   r_out_valid;
    logic [BIN_IDX_W-1:0]   r_bin_index;

    assign n_stat.in_valid = i_in_valid;
    assign n_stat.first    = i_first_item;
    assign n_stat.out_free = !r_out_valid || i_out_ready;
    assign n_stat.div_done = n_div_done;
    assign n_stat.dp       = n_dp_stat;

    cbp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (n_stat),
        .o_op       (n_op),
        .o_in_ready (o_in_ready)
    );

    cbp_dp #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (n_op),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data    (i_cfg_data),
        .i_item_weight (i_item_weight),
        .i_quotient    (n_quotient),
        .o_dividend    (n_dividend),
        .o_divisor     (n_divisor),
        .o_bin_index   (n_bin),
        .o_stat        (n_dp_stat)
    );

    cbp_div #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .DIVISOR_W   (BR)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_op == OP_OPEN),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_quotient (n_quotient),
        .o_done     (n_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_op == OP_EMIT) begin
            r_bin_index <= n_bin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_bin_index;

endmodule

// ===== hdl/cbp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_chk
// Port-level checks of the partitioner: output hold, reset, and one item in
// flight at a time.
// ----------------------------------------------------------------------------
module cbp_chk
    import cbp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [BIN_IDX_W-1:0] o_bin_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_index))
        else $error("output item dropped or changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while no item was in work");

endmodule

bind contiguous_balanced_partitioner_core cbp_chk u_cbp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_bin_index (o_bin_index)
);

// ===== tb/cbp_bin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_bin_checker
// Watches the config port and both item channels of the partitioner, works
// out the bin of every accepted item with its own copy of the cut state, and
// compares each returned bin index with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cbp_bin_checker
    import cbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [ITEM_W_W-1:0]  i_item_weight,
    input  logic                 i_first_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [BIN_IDX_W-1:0] i_bin_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int BIN_LIMIT = 16;

    logic [BIN_COUNT_W-1:0]  cfg_bins;
    logic [TOTAL_W-1:0]      cfg_total;
    logic [ITEM_COUNT_W-1:0] cfg_count;

    logic [BIN_IDX_W-1:0]    open_bin_idx;
    logic [31:0]             fill;
    logic [31:0]             weight_left;
    logic [31:0]             share;
    logic [BIN_COUNT_W-1:0]  bins_left;
    logic [ITEM_COUNT_W-1:0] placed;

    logic [BIN_IDX_W-1:0]    expected_bins[$];
    int                      mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_bins.size();

    function automatic void open_next_bin();
        fill  = '0;
        share = (bins_left <= 1) ? weight_left : weight_left / bins_left;
    endfunction

    function automatic void close_open_bin();
        weight_left = (weight_left > fill) ? weight_left - fill : '0;
        bins_left--;
        open_bin_idx++;
        open_next_bin();
    endfunction

    function automatic logic [BIN_IDX_W-1:0] place_item(logic [ITEM_W_W-1:0] w,
                                                        logic first);
        logic [BIN_COUNT_W-1:0]  n;
        logic [ITEM_COUNT_W-1:0] items_left;
        logic [31:0]             gap;
        logic [31:0]             wide_w;
        logic [32:0]             sum;
        logic [BIN_IDX_W-1:0]    bin;
        logic                    settled;
        int                      k;
        wide_w = {8'd0, w};
        if (first) begin
            n = cfg_bins;
            if (n == 0) n = BIN_COUNT_W'(1);
            if (n > BIN_LIMIT) n = BIN_COUNT_W'(BIN_LIMIT);
            bins_left    = n;
            open_bin_idx = '0;
            weight_left  = cfg_total;
            placed       = '0;
            open_next_bin();
        end
        settled = 1'b0;
        for (k = 0; k < BIN_LIMIT + 2 && !settled; k++) begin
            if (bins_left <= 1) begin
                settled = 1'b1;
            end else begin
                items_left = (placed < cfg_count) ? cfg_count - placed : '0;
                gap = share - fill;
                if (items_left <= bins_left - 1) begin
                    close_open_bin();
                end else if (fill != 0 && fill >= share) begin
                    close_open_bin();
                end else if (fill != 0 && wide_w > gap && wide_w - gap > gap) begin
                    close_open_bin();
                end else begin
                    settled = 1'b1;
                end
            end
        end
        bin = open_bin_idx;
        sum = {1'b0, fill} + {1'b0, wide_w};
        fill = sum[32] ? '1 : sum[31:0];
        if (placed != '1) placed++;
        return bin;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_bins     = 5'd2;
            cfg_total    = '0;
            cfg_count    = 16'd1;
            open_bin_idx = '0;
            fill         = '0;
            weight_left  = '0;
            share        = '0;
            bins_left    = '0;
            placed       = '0;
            expected_bins.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIN_COUNT:  cfg_bins  = i_cfg_data[BIN_COUNT_W-1:0];
                    CFG_TOTAL:      cfg_total = i_cfg_data[TOTAL_W-1:0];
                    CFG_ITEM_COUNT: cfg_count = i_cfg_data[ITEM_COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_bins = {expected_bins, place_item(i_item_weight, i_first_item)};
            if (i_out_valid && i_out_ready) begin
                if (expected_bins.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected item, bin_index %0d", $realtime,
                                 i_bin_index);
                end else begin
                    if (i_bin_index !== expected_bins[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: bin_index mismatch, expected %0d actual %0d",
                                     $realtime, expected_bins[0], i_bin_index);
                    end
                    void'(expected_bins.pop_front());
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

// ===== tb/contiguous_balanced_partitioner_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_balanced_partitioner_core_tb
// Drives weight sets, most sorted, through the partitioner under random
// config and random stalls on both channels; a checker beside the block
// predicts each bin index, counts mismatches; this top gives the verdict.
// ----------------------------------------------------------------------------
module contiguous_balanced_partitioner_core_tb;
    import cbp_pkg::*;

    localparam int       ITEMS       = 750;
    localparam int       CALM_TAIL   = 80;
    localparam int       CYCLE_LIMIT = 2_000_000;
    localparam int       TAIL_CYCLES = 700;
    localparam t_cfg_idx CFG_UNUSED  = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ITEM_W_W-1:0]  i_item_weight;
    logic                 i_first_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BIN_IDX_W-1:0] o_bin_index;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int                   fail_count;
    int                   pending;
    int                   cycles;
    int                   items_sent;
    int                   idle_pct;
    bit                   calm;
    logic [ITEM_W_W-1:0]  set_w[$];

    contiguous_balanced_partitioner_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_item_weight (i_item_weight),
        .i_first_item  (i_first_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bin_index   (o_bin_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cbp_bin_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_item_weight (i_item_weight),
        .i_first_item  (i_first_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_bin_index   (o_bin_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 99) < idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] weight_sum();
        logic [31:0] s;
        s = '0;
        foreach (set_w[i]) s += set_w[i];
        return s;
    endfunction

    task automatic send_item(input logic [ITEM_W_W-1:0] w, input logic first);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_item_weight <= w;
        i_first_item  <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (items_sent > ITEMS - CALM_TAIL) calm = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_set(input bit mark_first, input int restart_at);
        foreach (set_w[i])
            send_item(set_w[i], (mark_first && i == 0) || i == restart_at);
    endtask

    // hold off until every predicted item has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [BIN_COUNT_W-1:0] bin_cnt,
                             input logic [TOTAL_W-1:0] total,
                             input logic [ITEM_COUNT_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BIN_COUNT;
        i_cfg_data  <= CFG_W'(bin_cnt);
        @(negedge i_clk);
        i_cfg_index <= CFG_TOTAL;
        i_cfg_data  <= CFG_W'(total);
        @(negedge i_clk);
        i_cfg_index <= CFG_ITEM_COUNT;
        i_cfg_data  <= CFG_W'(count);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_set(input logic [BIN_COUNT_W-1:0] bin_cnt,
                           input logic [TOTAL_W-1:0] total,
                           input logic [ITEM_COUNT_W-1:0] count,
                           input int restart_at);
        drain();
        write_cfg(bin_cnt, total, count);
        send_set(1'b1, restart_at);
    endtask

    initial begin
        int                      n;
        int                      kind;
        int                      top_w;
        logic [BIN_COUNT_W-1:0]  bin_cnt;
        logic [TOTAL_W-1:0]      total;
        logic [ITEM_COUNT_W-1:0] count;
        int                      restart_at;

        cycles        = 0;
        items_sent    = 0;
        calm          = 1'b0;
        idle_pct      = 20;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_item_weight = '0;
        i_first_item  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BIN_COUNT;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // items ahead of any set start land in bin 0
        set_w = '{24'd7, 24'hFFFFFF};
        send_set(1'b0, -1);
        // reset config: two bins, zero total, one item
        drain();
        set_w = '{24'h20, 24'h10};
        send_set(1'b1, -1);

        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 32'hA5A5_5A5A;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;

        set_w = '{24'hFFFFFF, 24'h800000, 24'h001234, 24'd1, 24'd0};
        run_set(5'd4, weight_sum(), 16'd5, -1);
        set_w = '{24'd100, 24'd50};
        run_set(5'd0, weight_sum(), 16'd2, -1);
        set_w = '{24'd40, 24'd30, 24'd20, 24'd10};
        run_set(5'd31, weight_sum(), 16'd4, -1);
        set_w = '{24'd5, 24'd3, 24'd1};
        run_set(5'd3, 32'hFFFF_FFFF, 16'd3, -1);
        set_w = '{24'd100, 24'd50, 24'd20};
        run_set(5'd3, 32'd10, 16'd3, -1);
        set_w = '{24'd0, 24'd0};
        run_set(5'd2, 32'd0, 16'd0, -1);

        while (items_sent < ITEMS) begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 40;
            endcase
            kind = $urandom_range(0, 11);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 14);
            case ($urandom_range(0, 3))
                0:       top_w = 255;
                1:       top_w = 65535;
                default: top_w = 24'hFFFFFF;
            endcase
            set_w.delete();
            repeat (n) set_w = {set_w, ITEM_W_W'($urandom_range(0, top_w))};
            if (kind != 0) set_w.rsort();

            case ($urandom_range(0, 9))
                0:       bin_cnt = 5'd0;
                1:       bin_cnt = BIN_COUNT_W'($urandom_range(17, 31));
                default: bin_cnt = BIN_COUNT_W'($urandom_range(1, 16));
            endcase
            total = weight_sum();
            count = ITEM_COUNT_W'(n);
            restart_at = -1;
            case (kind)
                1: total = $urandom();
                2: total = total >> $urandom_range(1, 4);
                3: total = 32'hFFFF_FFFF;
                4: count = ITEM_COUNT_W'($urandom_range(0, n - 1));
                5: count = ($urandom_range(0, 1) == 0) ?
                           ITEM_COUNT_W'(n + $urandom_range(1, 20)) :
                           ITEM_COUNT_W'($urandom_range(0, 65535));
                6: if (n > 2) restart_at = $urandom_range(1, n - 1);
                default: ;
            endcase
            run_set(bin_cnt, total, count, restart_at);

            // restart the same set straight away, no drain
            if ($urandom_range(0, 3) == 0) send_set(1'b1, -1);
            // run on past the set's end without a new start
            if (kind == 7) begin
                repeat ($urandom_range(1, 4))
                    send_item(ITEM_W_W'($urandom_range(0, top_w)), 1'b0);
            end
            // new item count mid-stream, taken without a new start
            if (kind == 8) begin
                drain();
                write_cfg(bin_cnt, total, ITEM_COUNT_W'($urandom_range(0, 8)));
                repeat ($urandom_range(1, 3))
                    send_item(ITEM_W_W'($urandom_range(0, top_w)), 1'b0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
